// ===== hdl/rsc_pkg.sv =====
package rsc_pkg;

  // request kinds carried in tuser on the slave side
  localparam logic [1:0] REQ_REKEY  = 2'd0;
  localparam logic [1:0] REQ_HEADER = 2'd1;
  localparam logic [1:0] REQ_DATA   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // result kinds carried in tuser on the master side
  localparam logic [1:0] RES_HEADER = 2'd0;
  localparam logic [1:0] RES_BYTE   = 2'd1;
  localparam logic [1:0] RES_REKEY  = 2'd2;

  // header status codes
  localparam logic [2:0] ST_INORDER   = 3'd0;
  localparam logic [2:0] ST_SKIPPED   = 3'd1;
  localparam logic [2:0] ST_REORDERED = 3'd2;
  localparam logic [2:0] ST_TOO_AHEAD = 3'd3;
  localparam logic [2:0] ST_TOO_BACK  = 3'd4;

  // handling of the open packet
  localparam logic [2:0] PC_IDLE    = 3'd0;
  localparam logic [2:0] PC_SEND    = 3'd1;
  localparam logic [2:0] PC_INORDER = 3'd2;
  localparam logic [2:0] PC_SKIPPED = 3'd3;
  localparam logic [2:0] PC_REORDER = 3'd4;
  localparam logic [2:0] PC_REJECT  = 3'd5;

  // permutation table selectors
  localparam logic [1:0] PS_CUR = 2'd0;
  localparam logic [1:0] PS_SAV = 2'd1;
  localparam logic [1:0] PS_SCR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] seq_number;
    logic [7:0]  data_byte;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [31:0] seq_out;
    logic [2:0]  status;
    logic        last_out;
  } result_t;

endpackage

// ===== hdl/rsc_ram.sv =====
module rsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rsc_front.sv =====
module rsc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rsc_pkg::item_t in_item,
  input  logic           hold,
  output logic           q_valid,
  output rsc_pkg::item_t q_item,
  input  logic           q_pop
);

  rsc_pkg::item_t q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       accept;
  logic       push;

  // unused request kinds are taken and dropped here
  assign in_ready = (count != 2'd2) && !hold;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_item.req_type != rsc_pkg::REQ_NONE);
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hdl/rsc_back.sv =====
module rsc_back #(
  parameter int FORWARD_LIMIT = 10485760,
  parameter int BACK_LIMIT    = 102400,
  parameter int KEY_BYTES     = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             decrypt_mode,
  input  logic [127:0]     key,
  input  logic             q_valid,
  input  rsc_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             hold,
  output logic             out_valid,
  input  logic             out_ready,
  output rsc_pkg::result_t out_item
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILL   = 4'd1;
  localparam logic [3:0] S_KSA    = 4'd2;
  localparam logic [3:0] S_COPY   = 4'd3;
  localparam logic [3:0] S_SKIP   = 4'd4;
  localparam logic [3:0] S_RD_I   = 4'd5;
  localparam logic [3:0] S_RD_J   = 4'd6;
  localparam logic [3:0] S_WR_I   = 4'd7;
  localparam logic [3:0] S_WR_J   = 4'd8;
  localparam logic [3:0] S_RD_T   = 4'd9;
  localparam logic [3:0] S_GET_T  = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;
  localparam logic [3:0] S_ENDPKT = 4'd12;

  localparam logic [1:0] JOB_KSA  = 2'd0;
  localparam logic [1:0] JOB_SKIP = 2'd1;
  localparam logic [1:0] JOB_DATA = 2'd2;

  localparam logic [31:0] FWD_LIM  = 32'(FORWARD_LIMIT);
  localparam logic [31:0] BACK_LIM = 32'(BACK_LIMIT);
  localparam logic [3:0]  KEY_LAST = 4'(KEY_BYTES - 1);

  logic [3:0]  state;
  logic [3:0]  ret;
  logic [1:0]  job;
  logic        init_done;
  logic        rekey_run;
  logic [8:0]  kcnt;
  logic [1:0]  psel;
  logic [1:0]  csrc;
  logic [1:0]  cdst;
  logic [7:0]  wi;
  logic [7:0]  wj;
  logic [7:0]  si;
  logic [7:0]  sj;
  logic [3:0]  kidx;
  logic [31:0] cnt;

  logic [15:0] cur_ij;
  logic [15:0] sav_ij;
  logic [15:0] scr_ij;
  logic [31:0] pos;
  logic        sv;
  logic [31:0] last_gap;
  logic [31:0] sav_pos;
  logic [2:0]  pcase;

  rsc_pkg::item_t   itm;
  rsc_pkg::result_t res;

  // table port control
  logic [1:0] rs;
  logic [1:0] ws;
  logic       we;
  logic [7:0] waddr;
  logic [7:0] wdata;
  logic [7:0] raddr;
  logic [7:0] rd_cur;
  logic [7:0] rd_sav;
  logic [7:0] rd_scr;
  logic [7:0] rdata;
  logic [7:0] keyadd;
  logic [7:0] j_new;
  logic [15:0] ij_sel;

  // header classification
  logic [31:0] gap;
  logic [31:0] back_mag;
  logic [31:0] dd_hdr;
  logic [31:0] dd_end;
  logic        sv_end;
  logic [2:0]  hdr_st;

  assign rs = (state == S_COPY) ? csrc : psel;
  assign ws = (state == S_COPY) ? cdst : ((state == S_FILL) ? rsc_pkg::PS_CUR : psel);

  always_comb begin
    case (rs)
      rsc_pkg::PS_SAV: rdata = rd_sav;
      rsc_pkg::PS_SCR: rdata = rd_scr;
      default:         rdata = rd_cur;
    endcase
  end

  always_comb begin
    case (psel)
      rsc_pkg::PS_SAV: ij_sel = sav_ij;
      rsc_pkg::PS_SCR: ij_sel = scr_ij;
      default:         ij_sel = cur_ij;
    endcase
  end

  assign keyadd = (job == JOB_KSA) ? key[{kidx, 3'b000} +: 8] : 8'd0;
  assign j_new  = wj + rdata + keyadd;

  always_comb begin
    we    = 1'b0;
    waddr = 8'd0;
    wdata = 8'd0;
    raddr = 8'd0;
    unique case (state)
      S_FILL: begin
        we    = 1'b1;
        waddr = kcnt[7:0];
        wdata = kcnt[7:0];
      end
      S_COPY: begin
        we    = (kcnt != 9'd0);
        waddr = kcnt[7:0] - 8'd1;
        wdata = rdata;
        raddr = kcnt[7:0];
      end
      S_RD_I: raddr = wi;
      S_RD_J: raddr = j_new;
      S_WR_I: begin
        we    = 1'b1;
        waddr = wi;
        wdata = rdata;
      end
      S_WR_J: begin
        we    = 1'b1;
        waddr = wj;
        wdata = si;
      end
      S_RD_T: raddr = si + sj;
      default: ;
    endcase
  end

  rsc_ram #(.WIDTH(8), .DEPTH(256)) u_cur (
    .clk(clk), .we(we && (ws == rsc_pkg::PS_CUR)), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_cur)
  );
  rsc_ram #(.WIDTH(8), .DEPTH(256)) u_sav (
    .clk(clk), .we(we && (ws == rsc_pkg::PS_SAV)), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_sav)
  );
  rsc_ram #(.WIDTH(8), .DEPTH(256)) u_scr (
    .clk(clk), .we(we && (ws == rsc_pkg::PS_SCR)), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_scr)
  );

  assign gap      = q_item.seq_number - pos;
  assign back_mag = pos - q_item.seq_number;
  assign dd_hdr   = q_item.seq_number - sav_pos;
  assign sv_end   = sv && !((pcase == rsc_pkg::PC_INORDER) &&
                    !(pos - last_gap >= 32'h8000_0000) && (pos - last_gap > BACK_LIM));
  assign dd_end   = pos - BACK_LIM - sav_pos;

  // header status from the gap to the current position
  always_comb begin
    if (!decrypt_mode || gap == 32'd0) begin
      hdr_st = rsc_pkg::ST_INORDER;
    end else if (!gap[31]) begin
      hdr_st = (gap > FWD_LIM) ? rsc_pkg::ST_TOO_AHEAD : rsc_pkg::ST_SKIPPED;
    end else if (!sv || back_mag > BACK_LIM || dd_hdr[31]) begin
      hdr_st = rsc_pkg::ST_TOO_BACK;
    end else begin
      hdr_st = rsc_pkg::ST_REORDERED;
    end
  end

  assign hold  = !init_done;
  assign q_pop = (state == S_IDLE) && q_valid && init_done;

  // result holding register
  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (q_pop) begin
      itm <= q_item;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      ret       <= S_IDLE;
      job       <= JOB_SKIP;
      init_done <= 1'b0;
      rekey_run <= 1'b0;
      kcnt      <= 9'd0;
      psel      <= rsc_pkg::PS_CUR;
      csrc      <= rsc_pkg::PS_CUR;
      cdst      <= rsc_pkg::PS_SAV;
      cnt       <= 32'd0;
      kidx      <= 4'd0;
      wi        <= 8'd0;
      wj        <= 8'd0;
      cur_ij    <= 16'd0;
      sav_ij    <= 16'd0;
      scr_ij    <= 16'd0;
      pos       <= 32'd0;
      sv        <= 1'b0;
      last_gap  <= 32'd0;
      sav_pos   <= 32'd0;
      pcase     <= rsc_pkg::PC_IDLE;
      res       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid && init_done) begin
            case (q_item.req_type)
              rsc_pkg::REQ_REKEY: begin
                res       <= '0;
                rekey_run <= 1'b1;
                kcnt      <= 9'd0;
                state     <= S_FILL;
              end
              rsc_pkg::REQ_HEADER: begin
                res <= {rsc_pkg::RES_HEADER, 8'd0, pos, hdr_st, q_item.last_byte};
                ret <= S_EMIT;
                job <= JOB_SKIP;
                if (!decrypt_mode) begin
                  pcase <= rsc_pkg::PC_SEND;
                  state <= S_EMIT;
                end else if (gap == 32'd0) begin
                  pcase <= rsc_pkg::PC_INORDER;
                  state <= S_EMIT;
                end else if (!gap[31]) begin
                  if (gap > FWD_LIM) begin
                    pcase <= rsc_pkg::PC_REJECT;
                    state <= S_EMIT;
                  end else begin
                    last_gap <= q_item.seq_number;
                    pos      <= q_item.seq_number;
                    pcase    <= rsc_pkg::PC_SKIPPED;
                    cnt      <= gap;
                    psel     <= rsc_pkg::PS_CUR;
                    if (!sv) begin
                      sv      <= 1'b1;
                      sav_pos <= pos;
                      sav_ij  <= cur_ij;
                      csrc    <= rsc_pkg::PS_CUR;
                      cdst    <= rsc_pkg::PS_SAV;
                      kcnt    <= 9'd0;
                      state   <= S_COPY;
                    end else begin
                      state <= S_SKIP;
                    end
                  end
                end else if (!sv || back_mag > BACK_LIM || dd_hdr[31]) begin
                  pcase <= rsc_pkg::PC_REJECT;
                  state <= S_EMIT;
                end else begin
                  pcase  <= rsc_pkg::PC_REORDER;
                  scr_ij <= sav_ij;
                  cnt    <= dd_hdr;
                  psel   <= rsc_pkg::PS_SCR;
                  csrc   <= rsc_pkg::PS_SAV;
                  cdst   <= rsc_pkg::PS_SCR;
                  kcnt   <= 9'd0;
                  state  <= S_COPY;
                end
              end
              rsc_pkg::REQ_DATA: begin
                if (pcase == rsc_pkg::PC_IDLE) begin
                  state <= S_IDLE;
                end else if (pcase == rsc_pkg::PC_REJECT) begin
                  state <= q_item.last_byte ? S_ENDPKT : S_IDLE;
                end else begin
                  res <= {rsc_pkg::RES_BYTE, 8'd0, 32'd0, 3'd0, q_item.last_byte};
                  job <= JOB_DATA;
                  ret <= S_EMIT;
                  cnt <= 32'd1;
                  if (pcase == rsc_pkg::PC_REORDER) begin
                    psel <= rsc_pkg::PS_SCR;
                  end else begin
                    psel <= rsc_pkg::PS_CUR;
                    pos  <= pos + 32'd1;
                  end
                  state <= S_SKIP;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // identity fill of the current table
        S_FILL: begin
          kcnt <= kcnt + 9'd1;
          if (kcnt[7:0] == 8'hff) begin
            init_done <= 1'b1;
            state     <= rekey_run ? S_KSA : S_IDLE;
          end
        end
        S_KSA: begin
          rekey_run <= 1'b0;
          job       <= JOB_KSA;
          psel      <= rsc_pkg::PS_CUR;
          wi        <= 8'd0;
          wj        <= 8'd0;
          kidx      <= 4'd0;
          state     <= S_RD_I;
        end
        // table copy, one entry a cycle
        S_COPY: begin
          kcnt <= kcnt + 9'd1;
          if (kcnt == 9'd256) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (cnt == 32'd0) begin
            state <= ret;
          end else begin
            wi    <= ij_sel[15:8] + 8'd1;
            wj    <= ij_sel[7:0];
            state <= S_RD_I;
          end
        end
        S_RD_I: state <= S_RD_J;
        S_RD_J: begin
          si    <= rdata;
          wj    <= j_new;
          state <= S_WR_I;
        end
        S_WR_I: begin
          sj    <= rdata;
          state <= S_WR_J;
        end
        S_WR_J: begin
          if (job == JOB_KSA) begin
            kidx <= (kidx == KEY_LAST) ? 4'd0 : kidx + 4'd1;
            if (wi == 8'hff) begin
              cur_ij          <= 16'd0;
              sav_ij          <= 16'd0;
              scr_ij          <= 16'd0;
              pos             <= 32'd0;
              sv              <= 1'b0;
              last_gap        <= 32'd0;
              sav_pos         <= 32'd0;
              pcase           <= rsc_pkg::PC_IDLE;
              res.result_kind <= rsc_pkg::RES_REKEY;
              state           <= S_EMIT;
            end else begin
              wi    <= wi + 8'd1;
              state <= S_RD_I;
            end
          end else if (job == JOB_DATA) begin
            state <= S_RD_T;
          end else begin
            cnt <= cnt - 32'd1;
            if (cnt == 32'd1) begin
              case (psel)
                rsc_pkg::PS_SAV: sav_ij <= {wi, wj};
                rsc_pkg::PS_SCR: scr_ij <= {wi, wj};
                default:         cur_ij <= {wi, wj};
              endcase
              state <= ret;
            end else begin
              wi    <= wi + 8'd1;
              state <= S_RD_I;
            end
          end
        end
        S_RD_T: state <= S_GET_T;
        S_GET_T: begin
          res.out_byte <= itm.data_byte ^ rdata;
          cnt          <= 32'd0;
          if (psel == rsc_pkg::PS_SCR) begin
            scr_ij <= {wi, wj};
          end else begin
            cur_ij <= {wi, wj};
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            state <= res.last_out ? S_ENDPKT : S_IDLE;
          end
        end
        // end of packet: drop or advance the saved state
        S_ENDPKT: begin
          sv    <= sv_end;
          pcase <= rsc_pkg::PC_IDLE;
          job   <= JOB_SKIP;
          ret   <= S_IDLE;
          if ((pcase == rsc_pkg::PC_INORDER || pcase == rsc_pkg::PC_SKIPPED) && sv_end &&
              !dd_end[31] && dd_end != 32'd0) begin
            sav_pos <= sav_pos + dd_end;
            cnt     <= dd_end;
            psel    <= rsc_pkg::PS_SAV;
            state   <= S_SKIP;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/rc4_stream_resync_cipher_top.sv =====
// A data byte leaves the queue, takes one keystream swap (read i, read j, write i and j),
// reads its keystream byte and reaches the output register; a header may first run a
// table copy and a skip of one swap per keystream byte. A rekey runs the identity fill,
// a set-up step and the key schedule. Closing a packet may advance the saved copy.
// Throughput is one item at a time, set by the single port pair of each 256-entry table.
// Reset (rst, synchronous) clears the control state, then the fill runs with tready low.
module rc4_stream_resync_cipher_top #(
  parameter int FORWARD_LIMIT = 10485760,
  parameter int BACK_LIMIT    = 102400,
  parameter int KEY_BYTES     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // seq_number, data_byte
  input  logic [1:0]  s_axis_tuser,  // req_type
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_byte, seq_out, status, zero pad
  output logic [1:0]  m_axis_tuser,  // result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic        decrypt_mode;
  logic [63:0] key_low;
  logic [63:0] key_high;

  rsc_pkg::item_t   in_item;
  rsc_pkg::item_t   q_item;
  rsc_pkg::result_t out_item;
  logic             q_valid;
  logic             q_pop;
  logic             hold;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      key_low      <= 64'd0;
      key_high     <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsc_pkg::CFG_MODE:     decrypt_mode <= cfg_data[0];
        rsc_pkg::CFG_KEY_LOW:  key_low      <= cfg_data;
        rsc_pkg::CFG_KEY_HIGH: key_high     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.req_type   = s_axis_tuser;
  assign in_item.seq_number = s_axis_tdata[31:0];
  assign in_item.data_byte  = s_axis_tdata[39:32];
  assign in_item.last_byte  = s_axis_tlast;

  rsc_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .hold(hold), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  rsc_back #(
    .FORWARD_LIMIT(FORWARD_LIMIT), .BACK_LIMIT(BACK_LIMIT), .KEY_BYTES(KEY_BYTES)
  ) u_back (
    .clk(clk), .rst(rst),
    .decrypt_mode(decrypt_mode), .key({key_high, key_low}),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .hold(hold),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_item(out_item)
  );

  assign m_axis_tdata = {5'd0, out_item.status, out_item.seq_out, out_item.out_byte};
  assign m_axis_tuser = out_item.result_kind;
  assign m_axis_tlast = out_item.last_out;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int FWD_LIM    = 10485760;
  localparam int BACK_LIM   = 102400;
  localparam int KEY_LEN    = 16;
  localparam int DOG_LIMIT  = 2000000;
  localparam int SETTLE_CYC = 20000;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // seq_number, data_byte
  logic [1:0]  s_axis_tuser = '0;  // req_type
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // out_byte, seq_out, status, zero pad
  logic [1:0]  m_axis_tuser;       // result_kind
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  rc4_stream_resync_cipher_top DUT (.*);

  always #4 clk = ~clk;

  // cipher state as the block should hold it
  logic [7:0]  cur_tab [256];
  logic [7:0]  sav_tab [256];
  logic [7:0]  scr_tab [256];
  logic [15:0] cur_ij, sav_ij, scr_ij;
  logic [31:0] pos_q, gap_seq_q, sav_pos_q;
  logic        sav_ok;
  logic [2:0]  pkt_case;
  logic        rx_mode;
  logic [63:0] key_lo, key_hi;

  rsc_pkg::item_t   pend_items[$];
  rsc_pkg::result_t want_q[$];
  int      errors = 0;
  bit      calm = 1'b0;
  bit      drive_busy = 1'b0;

  function automatic logic [7:0] keystream(ref logic [7:0] s [256], ref logic [15:0] ij);
    logic [7:0] i, j, t;
    i = ij[15:8] + 8'd1;
    j = ij[7:0] + s[i];
    t = s[i];
    s[i] = s[j];
    s[j] = t;
    ij = {i, j};
    return s[8'(s[i] + s[j])];
  endfunction

  function automatic void advance(ref logic [7:0] s [256], ref logic [15:0] ij,
                                  input logic [31:0] n);
    logic [7:0] d;
    for (logic [31:0] k = 0; k < n; k++) d = keystream(s, ij);
  endfunction

  // signed 32-bit value strictly above a non-negative limit
  function automatic bit above(logic [31:0] x, logic [31:0] lim);
    return !x[31] && x > lim;
  endfunction

  function automatic void wipe_counters();
    cur_ij = '0; sav_ij = '0; scr_ij = '0;
    pos_q = '0; sav_ok = 1'b0; gap_seq_q = '0; sav_pos_q = '0;
    pkt_case = rsc_pkg::PC_IDLE;
  endfunction

  function automatic void close_packet();
    logic [31:0] dd;
    if (pkt_case == rsc_pkg::PC_INORDER && sav_ok && above(pos_q - gap_seq_q, BACK_LIM))
      sav_ok = 1'b0;
    if ((pkt_case == rsc_pkg::PC_INORDER || pkt_case == rsc_pkg::PC_SKIPPED) && sav_ok) begin
      dd = pos_q - BACK_LIM - sav_pos_q;
      if (above(dd, 0)) begin
        advance(sav_tab, sav_ij, dd);
        sav_pos_q += dd;
      end
    end
    pkt_case = rsc_pkg::PC_IDLE;
  endfunction

  // works out the result of one accepted item, if any
  function automatic void cipher_step(rsc_pkg::item_t it);
    rsc_pkg::result_t r;
    logic [31:0] d, dd;
    logic [7:0] ks, j, t, kb;
    r = '0;
    case (it.req_type)
      rsc_pkg::REQ_REKEY: begin
        for (int i = 0; i < 256; i++) cur_tab[i] = 8'(i);
        j = 8'd0;
        for (int i = 0; i < 256; i++) begin
          kb = ((i % KEY_LEN) < 8) ? 8'(key_lo >> (8 * (i % KEY_LEN)))
                                   : 8'(key_hi >> (8 * ((i % KEY_LEN) - 8)));
          j = j + cur_tab[i] + kb;
          t = cur_tab[i]; cur_tab[i] = cur_tab[j]; cur_tab[j] = t;
        end
        wipe_counters();
        r.result_kind = rsc_pkg::RES_REKEY;
        want_q.push_back(r);
      end
      rsc_pkg::REQ_HEADER: begin
        r.result_kind = rsc_pkg::RES_HEADER;
        r.seq_out = pos_q;
        r.status = rsc_pkg::ST_INORDER;
        r.last_out = it.last_byte;
        if (!rx_mode) begin
          pkt_case = rsc_pkg::PC_SEND;
        end else begin
          d = it.seq_number - pos_q;
          if (d == 0) begin
            pkt_case = rsc_pkg::PC_INORDER;
          end else if (!d[31]) begin
            if (d > FWD_LIM) begin
              pkt_case = rsc_pkg::PC_REJECT; r.status = rsc_pkg::ST_TOO_AHEAD;
            end else begin
              gap_seq_q = it.seq_number;
              if (!sav_ok) begin
                sav_ok = 1'b1; sav_pos_q = pos_q; sav_tab = cur_tab; sav_ij = cur_ij;
              end
              advance(cur_tab, cur_ij, d);
              pos_q = it.seq_number;
              pkt_case = rsc_pkg::PC_SKIPPED; r.status = rsc_pkg::ST_SKIPPED;
            end
          end else begin
            dd = it.seq_number - sav_pos_q;
            if (!sav_ok || (0 - d) > BACK_LIM || dd[31]) begin
              pkt_case = rsc_pkg::PC_REJECT; r.status = rsc_pkg::ST_TOO_BACK;
            end else begin
              scr_tab = sav_tab; scr_ij = sav_ij;
              advance(scr_tab, scr_ij, dd);
              pkt_case = rsc_pkg::PC_REORDER; r.status = rsc_pkg::ST_REORDERED;
            end
          end
        end
        want_q.push_back(r);
        if (it.last_byte) close_packet();
      end
      rsc_pkg::REQ_DATA: begin
        if (pkt_case == rsc_pkg::PC_REJECT) begin
          if (it.last_byte) close_packet();
        end else if (pkt_case != rsc_pkg::PC_IDLE) begin
          if (pkt_case == rsc_pkg::PC_REORDER) begin
            ks = keystream(scr_tab, scr_ij);
          end else begin
            ks = keystream(cur_tab, cur_ij);
            pos_q++;
          end
          r.result_kind = rsc_pkg::RES_BYTE;
          r.out_byte = it.data_byte ^ ks;
          r.last_out = it.last_byte;
          want_q.push_back(r);
          if (it.last_byte) close_packet();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  // input side
  int in_gap = 0;
  rsc_pkg::item_t cur_item;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cipher_step(cur_item);
        drive_busy = 1'b0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pend_items.size() > 0) begin
          cur_item = pend_items.pop_front();
          drive_busy = 1'b1;
          s_axis_tdata <= {cur_item.data_byte, cur_item.seq_number};
          s_axis_tuser <= cur_item.req_type;
          s_axis_tlast <= cur_item.last_byte;
          s_axis_tvalid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: stall at random and check every result
  always @(posedge clk) begin
    rsc_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: kind %0d tdata %h",
                                   m_axis_tuser, m_axis_tdata);
      end else begin
        want = want_q.pop_front();
        if (m_axis_tuser != want.result_kind || m_axis_tdata[7:0] != want.out_byte ||
            m_axis_tdata[39:8] != want.seq_out || m_axis_tdata[42:40] != want.status ||
            m_axis_tlast != want.last_out) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind %0d byte %h seq %h st %0d last %0b, got %0d %h %h %0d %0b",
                     want.result_kind, want.out_byte, want.seq_out, want.status,
                     want.last_out, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                     m_axis_tdata[42:40], m_axis_tlast);
        end
      end
    end
    m_axis_tready <= (rst || calm) ? 1'b1 : (pick_gap() == 0);
  end

  // watchdog on cycles with no handshake on either side
  int idle_cyc = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cyc = 0;
    else
      idle_cyc++;
    if (idle_cyc >= DOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic add(logic [1:0] req, logic [31:0] seq, logic [7:0] dat, logic lst);
    rsc_pkg::item_t it;
    it.req_type = req; it.seq_number = seq; it.data_byte = dat; it.last_byte = lst;
    pend_items.push_back(it);
  endtask

  task automatic wait_sent();
    while (pend_items.size() > 0 || drive_busy) @(posedge clk);
  endtask

  // wait for every result, then let trailing work finish
  task automatic settle();
    wait_sent();
    while (want_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == rsc_pkg::CFG_MODE) rx_mode = val[0];
    else if (idx == rsc_pkg::CFG_KEY_LOW) key_lo = val;
    else if (idx == rsc_pkg::CFG_KEY_HIGH) key_hi = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random packet or stray item, built from the current predicted state
  task automatic random_packet();
    int r, nb;
    logic [31:0] s, lim;
    r = $urandom_range(99);
    if (r < 3) begin
      add(rsc_pkg::REQ_REKEY, $urandom, 8'($urandom), 1'($urandom_range(1)));
      return;
    end
    if (r < 6) begin
      add($urandom_range(1) ? rsc_pkg::REQ_DATA : rsc_pkg::REQ_NONE, $urandom,
          8'($urandom), 1'($urandom_range(1)));
      return;
    end
    wait_sent();
    if (!rx_mode) begin
      s = $urandom;
    end else begin
      r = $urandom_range(99);
      if (r < 45) begin
        s = pos_q;
      end else if (r < 65) begin
        s = pos_q + $urandom_range(1, 200);
      end else if (r < 85) begin
        lim = pos_q - sav_pos_q + 20;
        if (!sav_ok || lim > 400) lim = 400;
        s = pos_q - $urandom_range(1, lim);
      end else if (r < 92) begin
        s = pos_q + FWD_LIM + $urandom_range(1, 1000);
      end else begin
        s = $urandom;
        if ((s - pos_q) != 0 && (s - pos_q) <= FWD_LIM) s ^= 32'h8000_0000;
      end
    end
    nb = $urandom_range(0, 8);
    add(rsc_pkg::REQ_HEADER, s, 8'($urandom), nb == 0);
    for (int k = 1; k <= nb; k++)
      add(rsc_pkg::REQ_DATA, $urandom, 8'($urandom), (k == nb) && ($urandom_range(9) != 0));
  endtask

  initial begin
    wipe_counters();
    for (int i = 0; i < 256; i++) begin
      cur_tab[i] = 8'(i); sav_tab[i] = '0; scr_tab[i] = '0;
    end
    rx_mode = 1'b0; key_lo = '0; key_hi = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // send mode, zero key, field extremes and stray items
    calm = 1'b1;
    add(rsc_pkg::REQ_DATA, '1, 8'hff, 1'b1);
    add(rsc_pkg::REQ_NONE, '1, 8'hff, 1'b1);
    add(rsc_pkg::REQ_REKEY, '0, '0, 1'b0);
    add(rsc_pkg::REQ_HEADER, '1, 8'hff, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h00, 1'b0);
    add(rsc_pkg::REQ_DATA, '1, 8'hff, 1'b1);
    add(rsc_pkg::REQ_HEADER, '0, '0, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'h1234, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h5a, 1'b0);
    settle();
    // receive mode set while a send packet is still open
    set_reg(rsc_pkg::CFG_MODE, 64'd1);
    set_reg(CFG_SPARE, '1);
    add(rsc_pkg::REQ_DATA, '0, 8'ha5, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd3, '0, 1'b0);
    add(rsc_pkg::REQ_HEADER, 32'd3, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h11, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd20, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h22, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd10, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h33, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd21 + FWD_LIM + 1, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h44, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h55, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'h8000_0000, '0, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd2, '0, 1'b1);
    settle();
    calm = 1'b0;

    // random phases through several keys and both modes
    for (int ph = 0; ph < 6; ph++) begin
      set_reg(rsc_pkg::CFG_MODE, 64'(ph % 2 == 0));
      set_reg(rsc_pkg::CFG_KEY_LOW, ph == 1 ? '1 : {$urandom, $urandom});
      set_reg(rsc_pkg::CFG_KEY_HIGH, ph == 2 ? '0 : ph == 1 ? '1 : {$urandom, $urandom});
      if (ph % 3 == 0) add(rsc_pkg::REQ_REKEY, '0, '0, 1'b0);
      calm = (ph == 4);
      for (int n = 0; n < 40; n++) random_packet();
      settle();
    end

    // long forward skip, then the saved copy is advanced and looked back upon
    calm = 1'b1;
    set_reg(rsc_pkg::CFG_MODE, 64'd1);
    add(rsc_pkg::REQ_REKEY, '0, '0, 1'b0);
    add(rsc_pkg::REQ_HEADER, 32'd0, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h01, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd102500, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h02, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd150, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h03, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd50, '0, 1'b1);
    add(rsc_pkg::REQ_HEADER, 32'd102501, '0, 1'b0);
    add(rsc_pkg::REQ_DATA, '0, 8'h04, 1'b1);
    wait_sent();
    while (want_q.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);

    if (errors == 0 && want_q.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
